// ----- hw/rtl/fdr_pkg.sv -----
// Package for the Fresnel dielectric reflectance core.
// Field widths, fixed-point constants, pipeline depths and the sideband struct.
// No dependencies.
package fdr_pkg;

    localparam int CosW      = 16;
    localparam int IorW      = 15;
    localparam int ReflW     = 17;
    localparam int InDataW   = 48;
    localparam int OutDataW  = 24;

    localparam int CW        = 15;
    localparam int SqW       = 30;
    localparam int S2W       = 29;
    localparam int LhsW      = 58;
    localparam int DivSteps  = 28;
    localparam int SqrtW     = 50;
    localparam int SqrtSteps = 25;
    localparam int CtW       = 25;
    localparam int ProdW     = 40;
    localparam int SumW      = 41;
    localparam int RatSteps  = 25;
    localparam int RatW      = 25;
    localparam int PowW      = 50;

    localparam logic [CW-1:0]    ONE_Q14 = 15'd16384;
    localparam logic [ReflW-1:0] ONE_Q16 = 17'd65536;
    localparam logic [SqW-1:0]   ONE_Q28 = 30'd268435456;

    typedef struct packed {
        logic            tir;
        logic            graze;
        logic [CW-1:0]   c;
        logic [IorW-1:0] ni;
        logic [IorW-1:0] nt;
    } side_t;

endpackage

// ----- hw/rtl/fresnel_dielectric_reflectance_core.sv -----
// Fresnel dielectric reflectance core: unpolarized reflectance of a boundary.
// Throughput one request per cycle while no result waits with m_tready low.
// Depth set by the bit-per-stage divider (28), square root (25) and ratio dividers (25).
// The whole pipeline holds when a result waits and m_tready is low.
// Reset (rst_n low, asynchronous) clears all valid bits; data registers are not reset.
// Depends on fdr_pkg.
module fresnel_dielectric_reflectance_core (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // [15:0] cos_theta, [30:16] ior_incident, [45:31] ior_transmitted
    input  logic [fdr_pkg::InDataW-1:0]  s_tdata,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // [16:0] reflectance
    output logic [fdr_pkg::OutDataW-1:0] m_tdata,
    // [0] total_internal
    output logic                         m_tuser
);
    import fdr_pkg::*;

    logic en;

    // stage 1: side swap and cosine magnitude
    logic                 s1_valid_reg;
    side_t                s1_side_reg;
    logic [CosW-1:0]      raw;
    logic [CosW-1:0]      mag;
    side_t                s1_next;

    // stage 2: squares
    logic                 s2_valid_reg;
    side_t                s2_side_reg;
    logic [S2W-1:0]       s2_sin2_reg;
    logic [SqW-1:0]       s2_ni2_reg;
    logic [SqW-1:0]       s2_nt2_reg;
    logic [SqW-1:0]       csq;

    // stage 3: lhs
    logic                 s3_valid_reg;
    side_t                s3_side_reg;
    logic [LhsW-1:0]      s3_lhs_reg;
    logic [SqW-1:0]       s3_nt2_reg;
    logic [LhsW:0]        lhs_prod;

    // divider
    logic                 dv_valid_reg [0:DivSteps];
    side_t                dv_side_reg  [0:DivSteps];
    logic [SqW-1:0]       dv_rem_reg   [0:DivSteps];
    logic [DivSteps-1:0]  dv_lo_reg    [0:DivSteps];
    logic [DivSteps-1:0]  dv_q_reg     [0:DivSteps];
    logic [SqW-1:0]       dv_nt2_reg   [0:DivSteps];
    side_t                s4_side;

    // square root
    logic                 sq_valid_reg [0:SqrtSteps];
    side_t                sq_side_reg  [0:SqrtSteps];
    logic [SqrtW-1:0]     sq_v_reg     [0:SqrtSteps];
    logic [SqrtW-1:0]     sq_r_reg     [0:SqrtSteps];
    logic [S2W-1:0]       ct2;

    // products and sum/difference
    logic                 pr_valid_reg;
    side_t                pr_side_reg;
    logic [ProdW-1:0]     pr_x1_reg, pr_y1_reg, pr_x2_reg, pr_y2_reg;
    logic [CtW-1:0]       ct;
    logic [CtW-1:0]       cc;

    // ratio dividers
    logic                 rt_valid_reg [0:RatSteps];
    side_t                rt_side_reg  [0:RatSteps];
    logic [SumW-1:0]      rt_rem1_reg  [0:RatSteps];
    logic [SumW-1:0]      rt_sum1_reg  [0:RatSteps];
    logic [RatW-1:0]      rt_q1_reg    [0:RatSteps];
    logic [SumW-1:0]      rt_rem2_reg  [0:RatSteps];
    logic [SumW-1:0]      rt_sum2_reg  [0:RatSteps];
    logic [RatW-1:0]      rt_q2_reg    [0:RatSteps];

    // squares of ratios
    logic                 pw_valid_reg;
    side_t                pw_side_reg;
    logic [PowW-1:0]      pw_p1_reg, pw_p2_reg;

    // output
    logic                 out_valid_reg;
    logic [ReflW-1:0]     out_refl_reg;
    logic                 out_tir_reg;
    logic [PowW+1:0]      tot;
    logic [PowW-32:0]     rnd;
    logic [ReflW-1:0]     refl_next;

    assign en       = !out_valid_reg || m_tready;
    assign s_tready = en;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OutDataW-ReflW){1'b0}}, out_refl_reg};
    assign m_tuser  = out_tir_reg;

    // ---------------- stage 1
    always_comb
    begin
        raw = s_tdata[CosW-1:0];
        mag = raw[CosW-1] ? CosW'(~raw + 16'd1) : raw;
        s1_next.tir   = 1'b0;
        s1_next.graze = 1'b0;
        s1_next.c     = (mag > {1'b0, ONE_Q14}) ? ONE_Q14 : mag[CW-1:0];
        if (raw[CosW-1])
        begin
            s1_next.ni = s_tdata[CosW+2*IorW-1:CosW+IorW];
            s1_next.nt = s_tdata[CosW+IorW-1:CosW];
        end
        else
        begin
            s1_next.ni = s_tdata[CosW+IorW-1:CosW];
            s1_next.nt = s_tdata[CosW+2*IorW-1:CosW+IorW];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            pr_valid_reg  <= 1'b0;
            pw_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg  <= s_tvalid;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            pr_valid_reg  <= sq_valid_reg[SqrtSteps];
            pw_valid_reg  <= rt_valid_reg[RatSteps];
            out_valid_reg <= pw_valid_reg;
        end
    end

    // ---------------- stages 2, 3, 4
    assign csq      = SqW'(s1_side_reg.c) * SqW'(s1_side_reg.c);
    assign lhs_prod = (LhsW+1)'(s2_ni2_reg) * (LhsW+1)'(s2_sin2_reg);

    always_comb
    begin
        s4_side       = s3_side_reg;
        s4_side.tir   = s3_lhs_reg >= {s3_nt2_reg, {DivSteps{1'b0}}};
        s4_side.graze = (s3_side_reg.c == '0);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_side_reg   <= s1_next;
            s2_side_reg   <= s1_side_reg;
            s2_sin2_reg   <= S2W'(ONE_Q28 - csq);
            s2_ni2_reg    <= SqW'(s1_side_reg.ni) * SqW'(s1_side_reg.ni);
            s2_nt2_reg    <= SqW'(s1_side_reg.nt) * SqW'(s1_side_reg.nt);
            s3_side_reg   <= s2_side_reg;
            s3_lhs_reg    <= lhs_prod[LhsW-1:0];
            s3_nt2_reg    <= s2_nt2_reg;
            dv_side_reg[0] <= s4_side;
            dv_rem_reg[0]  <= s3_lhs_reg[LhsW-1:DivSteps];
            dv_lo_reg[0]   <= s3_lhs_reg[DivSteps-1:0];
            dv_q_reg[0]    <= '0;
            dv_nt2_reg[0]  <= s3_nt2_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dv_valid_reg[0] <= 1'b0;
        else if (en)
            dv_valid_reg[0] <= s3_valid_reg;
    end

    // ---------------- divider: transmitted sin^2 quotient, one bit per stage
    for (genvar k = 0; k < DivSteps; k++)
    begin : g_div
        logic [SqW:0] t;
        logic         ge;

        assign t  = {dv_rem_reg[k], dv_lo_reg[k][DivSteps-1]};
        assign ge = t >= {1'b0, dv_nt2_reg[k]};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_valid_reg[k+1] <= 1'b0;
            else if (en)
                dv_valid_reg[k+1] <= dv_valid_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv_side_reg[k+1] <= dv_side_reg[k];
                dv_rem_reg[k+1]  <= ge ? SqW'(t - {1'b0, dv_nt2_reg[k]}) : t[SqW-1:0];
                dv_lo_reg[k+1]   <= {dv_lo_reg[k][DivSteps-2:0], 1'b0};
                dv_q_reg[k+1]    <= {dv_q_reg[k][DivSteps-2:0], ge};
                dv_nt2_reg[k+1]  <= dv_nt2_reg[k];
            end
        end
    end

    // ---------------- transmitted cos^2, square root input
    assign ct2 = S2W'(ONE_Q28 - {2'b0, dv_q_reg[DivSteps]});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sq_valid_reg[0] <= 1'b0;
        else if (en)
            sq_valid_reg[0] <= dv_valid_reg[DivSteps];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_side_reg[0] <= dv_side_reg[DivSteps];
            sq_v_reg[0]    <= {1'b0, ct2, 20'b0};
            sq_r_reg[0]    <= '0;
        end
    end

    // ---------------- square root, one result bit per stage
    for (genvar k = 0; k < SqrtSteps; k++)
    begin : g_sqrt
        localparam logic [SqrtW-1:0] Bit = SqrtW'(1) << (2 * (SqrtSteps - 1 - k));
        logic [SqrtW-1:0] rb;
        logic             ge;

        assign rb = sq_r_reg[k] + Bit;
        assign ge = sq_v_reg[k] >= rb;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                sq_valid_reg[k+1] <= 1'b0;
            else if (en)
                sq_valid_reg[k+1] <= sq_valid_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sq_side_reg[k+1] <= sq_side_reg[k];
                sq_v_reg[k+1]    <= ge ? sq_v_reg[k] - rb : sq_v_reg[k];
                sq_r_reg[k+1]    <= ge ? (sq_r_reg[k] >> 1) + Bit : sq_r_reg[k] >> 1;
            end
        end
    end

    // ---------------- amplitude products
    assign ct = sq_r_reg[SqrtSteps][CtW-1:0];
    assign cc = {sq_side_reg[SqrtSteps].c, 10'b0};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pr_side_reg <= sq_side_reg[SqrtSteps];
            pr_x1_reg   <= ProdW'(sq_side_reg[SqrtSteps].nt) * ProdW'(cc);
            pr_y1_reg   <= ProdW'(sq_side_reg[SqrtSteps].ni) * ProdW'(ct);
            pr_x2_reg   <= ProdW'(sq_side_reg[SqrtSteps].ni) * ProdW'(cc);
            pr_y2_reg   <= ProdW'(sq_side_reg[SqrtSteps].nt) * ProdW'(ct);
        end
    end

    // ---------------- sum and difference
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rt_valid_reg[0] <= 1'b0;
        else if (en)
            rt_valid_reg[0] <= pr_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rt_side_reg[0] <= pr_side_reg;
            rt_rem1_reg[0] <= (pr_x1_reg >= pr_y1_reg) ? {1'b0, pr_x1_reg - pr_y1_reg}
                                                       : {1'b0, pr_y1_reg - pr_x1_reg};
            rt_sum1_reg[0] <= {1'b0, pr_x1_reg} + {1'b0, pr_y1_reg};
            rt_rem2_reg[0] <= (pr_x2_reg >= pr_y2_reg) ? {1'b0, pr_x2_reg - pr_y2_reg}
                                                       : {1'b0, pr_y2_reg - pr_x2_reg};
            rt_sum2_reg[0] <= {1'b0, pr_x2_reg} + {1'b0, pr_y2_reg};
            rt_q1_reg[0]   <= '0;
            rt_q2_reg[0]   <= '0;
        end
    end

    // ---------------- ratio dividers, one quotient bit per stage
    for (genvar k = 0; k < RatSteps; k++)
    begin : g_ratio
        logic [SumW:0] t1, t2;
        logic          ge1, ge2;

        if (k == 0)
        begin : g_first
            assign t1 = {1'b0, rt_rem1_reg[k]};
            assign t2 = {1'b0, rt_rem2_reg[k]};
        end
        else
        begin : g_rest
            assign t1 = {rt_rem1_reg[k], 1'b0};
            assign t2 = {rt_rem2_reg[k], 1'b0};
        end

        assign ge1 = t1 >= {1'b0, rt_sum1_reg[k]};
        assign ge2 = t2 >= {1'b0, rt_sum2_reg[k]};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                rt_valid_reg[k+1] <= 1'b0;
            else if (en)
                rt_valid_reg[k+1] <= rt_valid_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rt_side_reg[k+1] <= rt_side_reg[k];
                rt_sum1_reg[k+1] <= rt_sum1_reg[k];
                rt_sum2_reg[k+1] <= rt_sum2_reg[k];
                rt_rem1_reg[k+1] <= ge1 ? SumW'(t1 - {1'b0, rt_sum1_reg[k]}) : t1[SumW-1:0];
                rt_rem2_reg[k+1] <= ge2 ? SumW'(t2 - {1'b0, rt_sum2_reg[k]}) : t2[SumW-1:0];
                rt_q1_reg[k+1]   <= {rt_q1_reg[k][RatW-2:0], ge1};
                rt_q2_reg[k+1]   <= {rt_q2_reg[k][RatW-2:0], ge2};
            end
        end
    end

    // ---------------- squares and output
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pw_side_reg <= rt_side_reg[RatSteps];
            pw_p1_reg   <= PowW'(rt_q1_reg[RatSteps]) * PowW'(rt_q1_reg[RatSteps]);
            pw_p2_reg   <= PowW'(rt_q2_reg[RatSteps]) * PowW'(rt_q2_reg[RatSteps]);
        end
    end

    always_comb
    begin
        tot = {2'b0, pw_p1_reg} + {2'b0, pw_p2_reg} + (52'd1 << 32);
        rnd = tot[PowW+1:33];
        if (pw_side_reg.tir || pw_side_reg.graze)
            refl_next = ONE_Q16;
        else if (rnd > {2'b0, ONE_Q16})
            refl_next = ONE_Q16;
        else
            refl_next = rnd[ReflW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_refl_reg <= refl_next;
            out_tir_reg  <= pw_side_reg.tir;
        end
    end

endmodule

// ----- tb/tb.sv -----
// Testbench for fresnel_dielectric_reflectance_core.
// Directed table plus random requests, checked against tabulated values or an in-bench reflectance predictor.
// Depends on fdr_pkg and the core RTL.
module tb;
    import fdr_pkg::*;

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [InDataW-1:0]  s_tdata;
    logic                m_tvalid;
    logic                m_tready;
    logic [OutDataW-1:0] m_tdata;
    logic                m_tuser;

    typedef struct {
        logic [ReflW-1:0] refl;
        logic             tir;
    } refl_t;

    typedef struct {
        logic [CosW-1:0] cos_theta;
        logic [IorW-1:0] ni;
        logic [IorW-1:0] nt;
        logic            known;
        logic [ReflW-1:0] refl;
        logic            tir;
    } vec_t;

    refl_t  expected_q[$];
    vec_t   dir_tab[$];
    int     errors = 0;
    bit     no_idle = 0;
    bit     hold_off = 0;
    bit     done = 0;

    fresnel_dielectric_reflectance_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic logic [63:0] isqrt(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = '0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [63:0] amp_ratio(input logic [63:0] x, input logic [63:0] y);
        logic [63:0] d;
        logic [63:0] s;
        d = (x >= y) ? x - y : y - x;
        s = x + y;
        if (s == 0)
            return '0;
        return (d << 24) / s;
    endfunction

    function automatic refl_t fresnel_reflectance(input logic [CosW-1:0] raw,
                                                  input logic [IorW-1:0] ni_in,
                                                  input logic [IorW-1:0] nt_in);
        refl_t       r;
        logic [63:0] ni, nt, c, s2, lhs, rhs, ct, cc, rpar, rperp, refl;
        ni = 64'(ni_in);
        nt = 64'(nt_in);
        if (raw[CosW-1])
        begin
            ni = 64'(nt_in);
            nt = 64'(ni_in);
            c = 64'h10000 - 64'(raw);
        end
        else
            c = 64'(raw);
        if (c > 64'd16384)
            c = 64'd16384;
        s2 = (64'd1 << 28) - c * c;
        lhs = ni * ni * s2;
        rhs = (nt * nt) << 28;
        r.tir = 1'b0;
        r.refl = ONE_Q16;
        if (lhs >= rhs)
        begin
            r.tir = 1'b1;
            return r;
        end
        if (c == 0)
            return r;
        ct = isqrt(((64'd1 << 28) - lhs / (nt * nt)) << 20);
        cc = c << 10;
        rpar = amp_ratio(nt * cc, ni * ct);
        rperp = amp_ratio(ni * cc, nt * ct);
        refl = (rpar * rpar + rperp * rperp + (64'd1 << 32)) >> 33;
        if (refl > 64'd65536)
            refl = 64'd65536;
        r.refl = refl[ReflW-1:0];
        return r;
    endfunction

    task automatic add_row(input int ct, input int ni, input int nt,
                           input bit known, input int refl, input bit tir);
        vec_t v;
        v.cos_theta = ct[CosW-1:0];
        v.ni = ni[IorW-1:0];
        v.nt = nt[IorW-1:0];
        v.known = known;
        v.refl = refl[ReflW-1:0];
        v.tir = tir;
        dir_tab.push_back(v);
    endtask

    task automatic send_request(input vec_t v);
        refl_t p;
        p = fresnel_reflectance(v.cos_theta, v.ni, v.nt);
        if (v.known)
        begin
            p.refl = v.refl;
            p.tir = v.tir;
        end
        while (!no_idle && $urandom_range(99) < 12)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {2'b0, v.nt, v.ni, v.cos_theta};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        expected_q.push_back(p);
    endtask

    initial
    begin
        vec_t v;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        add_row(16384, 8192, 8192, 1, 0, 0);
        add_row(0, 8192, 12288, 1, 65536, 0);
        add_row(0, 0, 0, 1, 65536, 1);
        add_row(8192, 12288, 0, 1, 65536, 1);
        add_row(16384, 12288, 8192, 0, 0, 0);
        add_row(-16384, 12288, 8192, 0, 0, 0);
        add_row(-32768, 8192, 32767, 0, 0, 0);
        add_row(32767, 32767, 8192, 0, 0, 0);
        add_row(16385, 8192, 12288, 0, 0, 0);
        add_row(2000, 12288, 8192, 1, 65536, 1);
        add_row(-2000, 8192, 12288, 1, 65536, 1);
        add_row(8192, 0, 12288, 0, 0, 0);
        add_row(-8192, 12288, 0, 0, 0, 0);
        add_row(11585, 4096, 2048, 0, 0, 0);
        add_row(-1, 32767, 8192, 0, 0, 0);
        add_row(1, 8192, 32767, 0, 0, 0);
        add_row(16384, 32767, 32767, 1, 0, 0);
        add_row(12000, 16384, 8192, 0, 0, 0);
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (dir_tab[i])
            send_request(dir_tab[i]);
        for (int i = 0; i < 600; i++)
        begin
            no_idle = (i >= 200 && i < 300);
            hold_off = (i >= 350 && i < 360);
            case ($urandom_range(3))
                0: v.cos_theta = CosW'($urandom);
                1: v.cos_theta = CosW'($urandom_range(16384));
                default: v.cos_theta = -$signed(16'($urandom_range(16384)));
            endcase
            if ($urandom_range(9) == 0)
            begin
                v.ni = IorW'($urandom);
                v.nt = IorW'($urandom);
            end
            else
            begin
                v.ni = IorW'($urandom_range(32767, 8192));
                v.nt = IorW'($urandom_range(32767, 8192));
            end
            v.known = 1'b0;
            send_request(v);
        end
        s_tvalid <= 1'b0;
        done = 1;
    end

    initial
    begin
        int cnt;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off)
            begin
                m_tready <= 1'b0;
                for (cnt = 0; cnt < 300; cnt++)
                    @(posedge clk);
                hold_off = 0;
            end
            m_tready <= no_idle || ($urandom_range(99) >= 12);
        end
    end

    always @(posedge clk)
    begin
        refl_t e;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_q.size() == 0)
            begin
                $display("%0t unexpected result refl=%0d tir=%0b", $time,
                         m_tdata[ReflW-1:0], m_tuser);
                errors++;
            end
            else
            begin
                e = expected_q.pop_front();
                if (m_tdata[ReflW-1:0] !== e.refl)
                begin
                    $display("%0t reflectance expected %0d actual %0d", $time, e.refl,
                             m_tdata[ReflW-1:0]);
                    errors++;
                end
                if (m_tuser !== e.tir)
                begin
                    $display("%0t total_internal expected %0b actual %0b", $time, e.tir,
                             m_tuser);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        wait (done);
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (errors == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("tb: FAIL");
        $finish;
    end
endmodule
